### sv/r32x_pkg.sv
// r32x_pkg: shared types and constants for the 32-bit execute unit.
// Op numbering, status-word layout, exception priorities, sequencer states.
// No dependencies.
package r32x_pkg;

  localparam logic [5:0] OP_ADD     = 6'd0;
  localparam logic [5:0] OP_ADDI    = 6'd1;
  localparam logic [5:0] OP_SUB     = 6'd2;
  localparam logic [5:0] OP_SUBI    = 6'd3;
  localparam logic [5:0] OP_MUL     = 6'd4;
  localparam logic [5:0] OP_MULI    = 6'd5;
  localparam logic [5:0] OP_MULU    = 6'd6;
  localparam logic [5:0] OP_UMULI   = 6'd7;
  localparam logic [5:0] OP_DIV     = 6'd8;
  localparam logic [5:0] OP_DIVI    = 6'd9;
  localparam logic [5:0] OP_DIVU    = 6'd10;
  localparam logic [5:0] OP_UDIVI   = 6'd11;
  localparam logic [5:0] OP_REM     = 6'd12;
  localparam logic [5:0] OP_REMI    = 6'd13;
  localparam logic [5:0] OP_REMU    = 6'd14;
  localparam logic [5:0] OP_UREMI   = 6'd15;
  localparam logic [5:0] OP_AND     = 6'd16;
  localparam logic [5:0] OP_ANDI    = 6'd17;
  localparam logic [5:0] OP_OR      = 6'd18;
  localparam logic [5:0] OP_ORI     = 6'd19;
  localparam logic [5:0] OP_XOR     = 6'd20;
  localparam logic [5:0] OP_XORI    = 6'd21;
  localparam logic [5:0] OP_XNOR    = 6'd22;
  localparam logic [5:0] OP_XNOR_IMM = 6'd23;
  localparam logic [5:0] OP_SLL     = 6'd24;
  localparam logic [5:0] OP_SLLI    = 6'd25;
  localparam logic [5:0] OP_SLR     = 6'd26;
  localparam logic [5:0] OP_SLRI    = 6'd27;
  localparam logic [5:0] OP_SAR     = 6'd28;
  localparam logic [5:0] OP_SARI    = 6'd29;
  localparam logic [5:0] OP_LDHI    = 6'd30;
  localparam logic [5:0] OP_BEQ     = 6'd31;
  localparam logic [5:0] OP_BNE     = 6'd32;
  localparam logic [5:0] OP_BLE     = 6'd33;
  localparam logic [5:0] OP_BLEU    = 6'd34;
  localparam logic [5:0] OP_BLT     = 6'd35;
  localparam logic [5:0] OP_BLTU    = 6'd36;
  localparam logic [5:0] OP_BGE     = 6'd37;
  localparam logic [5:0] OP_BGEU    = 6'd38;
  localparam logic [5:0] OP_BGT     = 6'd39;
  localparam logic [5:0] OP_BGTU    = 6'd40;
  localparam logic [5:0] OP_J       = 6'd41;
  localparam logic [5:0] OP_JR      = 6'd42;
  localparam logic [5:0] OP_JAL     = 6'd43;
  localparam logic [5:0] OP_JALR    = 6'd44;
  localparam logic [5:0] OP_TRAP    = 6'd45;
  localparam logic [5:0] OP_RFX     = 6'd46;
  localparam logic [5:0] OP_MVFS    = 6'd47;
  localparam logic [5:0] OP_MVTS    = 6'd48;

  localparam logic [4:0] EXC_NONE = 5'd0;
  localparam logic [4:0] EXC_ILL  = 5'd17;
  localparam logic [4:0] EXC_PRV  = 5'd18;
  localparam logic [4:0] EXC_DIV  = 5'd19;
  localparam logic [4:0] EXC_TRP  = 5'd20;

  // status word bit positions
  localparam int S_OIE = 21;
  localparam int S_PIE = 22;
  localparam int S_IE  = 23;
  localparam int S_OUM = 24;
  localparam int S_PUM = 25;
  localparam int S_UM  = 26;

  localparam logic [31:0] VEC_ADDR = 32'hC000_0004;
  localparam logic [31:0] RESET_PC = 32'hFE00_0000;
  localparam logic [4:0]  LINK_REG = 5'd31;
  localparam logic [4:0]  SAVE_REG = 5'd30;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_AB,
    ST_RD_DL,
    ST_EXEC,
    ST_DIV,
    ST_FIN,
    ST_R30
  } state_t;

endpackage

### sv/r32x_div.sv
// r32x_div: unsigned 32/32 restoring divider, one quotient bit per cycle.
// Gives quotient and remainder when done is raised. Uses r32x_pkg nothing.
// Standalone; instantiated by the execute unit top level.
module r32x_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] quot,
  output logic [31:0] rem
);

  logic [4:0]  cnt;
  logic [31:0] dsr;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem, quot[31]};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 5'd31);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      if (!diff[32]) begin
        rem  <= diff[31:0];
        quot <= {quot[30:0], 1'b1};
      end else begin
        rem  <= shifted[31:0];
        quot <= {quot[30:0], 1'b0};
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still iterating");
  assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> done)
    else $error("divider finished without done pulse");
  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");

endmodule

### sv/risc32_execute_with_interrupts.sv
// risc32_execute_with_interrupts: top level of the 32-bit execute unit.
// Depends on r32x_pkg (ops, status layout, states) and r32x_div.
//
// Input channel (in_valid/in_stall): one decoded instruction per transfer,
// taken as executing at the current pc, plus a mask of device interrupts
// raised alongside it. Output channel (out_valid/out_stall): one result per
// instruction: next fetch pc, register write-back, status word and any
// interrupt or exception taken.
// The register file is a memory with registered reads, so operands come in
// over the read states ST_RD_AB and ST_RD_DL; then an execute state ST_EXEC
// and a finish state ST_FIN, where out_valid is set. No new transfer is
// taken until the unit is back in ST_IDLE; divide and remainder add ST_DIV,
// waiting on the shared one-bit-per-cycle divider. Taking an interrupt or
// exception adds ST_R30 afterwards to save the pc in r30 over the single
// write port. in_stall is high from a transfer until that work is done.
// A finished result sits in the output register; the next instruction is
// taken while it waits, but its finish cycle holds until the output is free.
// Reset (synchronous): pc 0xFE000000, status and pending vector cleared,
// output empty. Register contents other than r0 are undefined until written.
module risc32_execute_with_interrupts (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  op,
  input  logic [4:0]  rd_field,
  input  logic [4:0]  rs_field,
  input  logic [4:0]  rt_field,
  input  logic [15:0] imm16,
  input  logic [25:0] jump_offset,
  input  logic [15:0] irq_raise,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] fetch_pc,
  output logic        wb_enable,
  output logic [4:0]  wb_reg,
  output logic [31:0] wb_value,
  output logic [31:0] status_word,
  output logic        took_interrupt,
  output logic [4:0]  taken_priority
);

  r32x_pkg::state_t state, state_next;

  // latched instruction
  logic [5:0]  f_op;
  logic [4:0]  f_rd, f_rs, f_rt;
  logic [15:0] f_imm;
  logic [25:0] f_joff;
  logic [15:0] f_irq;

  // architectural state
  logic [31:0] pc, status, pending;

  // register file
  logic [31:0] regs [32];
  logic [4:0]  ra0, ra1, wa;
  logic [31:0] rd0, rd1, wd;
  logic        we;

  logic [31:0] a_q, b_q;

  // execute results
  logic [31:0] ex_wval, ex_next, ex_s;
  logic [4:0]  ex_exc, ex_wreg;
  logic        ex_wr, ex_isdiv, ex_neg, ex_rem;
  logic [31:0] x_wval, x_next, x_s;
  logic [4:0]  x_exc, x_wreg;
  logic        x_wr, x_neg;
  logic [31:0] x_dvd, x_dsr;

  logic        div_start, div_busy, div_done;
  logic [31:0] div_q, div_r;

  logic        fin_go;
  logic [31:0] save_pc;

  assign in_stall = (state != r32x_pkg::ST_IDLE);
  assign fin_go   = !out_valid || !out_stall;

  // register file: one write, two registered reads, r0 reads as zero
  always_ff @(posedge clk) begin
    if (we) regs[wa] <= wd;
    rd0 <= (ra0 == 5'd0) ? 32'd0 : regs[ra0];
    rd1 <= (ra1 == 5'd0) ? 32'd0 : regs[ra1];
  end

  always_comb begin
    ra0 = f_rd;
    ra1 = r32x_pkg::SAVE_REG;
    if (state == r32x_pkg::ST_RD_AB) begin
      ra0 = f_rs;
      ra1 = f_rt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      f_op   <= op;
      f_rd   <= rd_field;
      f_rs   <= rs_field;
      f_rt   <= rt_field;
      f_imm  <= imm16;
      f_joff <= jump_offset;
      f_irq  <= irq_raise;
    end
    if (state == r32x_pkg::ST_RD_DL) begin
      a_q <= rd0;
      b_q <= rd1;
    end
  end

  // execute: operands a_q, b_q, d = rd0, r30 = rd1
  always_comb begin
    logic [31:0] se, ze, d, boff, nxt, dsr;
    logic        sgn;
    se   = {{16{f_imm[15]}}, f_imm};
    ze   = {16'd0, f_imm};
    d    = rd0;
    nxt  = pc + 32'd4;
    boff = {se[29:0], 2'b00};
    x_wval = '0;
    x_next = nxt;
    x_s    = status;
    x_exc  = r32x_pkg::EXC_NONE;
    x_wr   = 1'b1;
    x_wreg = f_rd;
    sgn    = !f_op[1];
    dsr    = f_op[0] ? (sgn ? se : ze) : b_q;
    x_neg  = 1'b0;
    x_dvd  = a_q;
    x_dsr  = dsr;
    if (sgn) begin
      x_dvd = a_q[31] ? (32'd0 - a_q) : a_q;
      x_dsr = dsr[31] ? (32'd0 - dsr) : dsr;
      x_neg = f_op[2] ? a_q[31] : (a_q[31] ^ dsr[31]);
    end
    case (f_op)
      r32x_pkg::OP_ADD:   x_wval = a_q + b_q;
      r32x_pkg::OP_ADDI:  x_wval = a_q + se;
      r32x_pkg::OP_SUB:   x_wval = a_q - b_q;
      r32x_pkg::OP_SUBI:  x_wval = a_q - se;
      // one multiplier: dsr already picks rt or the extended immediate
      r32x_pkg::OP_MUL, r32x_pkg::OP_MULI, r32x_pkg::OP_MULU, r32x_pkg::OP_UMULI:
        x_wval = a_q * dsr;
      r32x_pkg::OP_DIV, r32x_pkg::OP_DIVI, r32x_pkg::OP_DIVU, r32x_pkg::OP_UDIVI,
      r32x_pkg::OP_REM, r32x_pkg::OP_REMI, r32x_pkg::OP_REMU, r32x_pkg::OP_UREMI:
        if (dsr == 32'd0) x_exc = r32x_pkg::EXC_DIV;
      r32x_pkg::OP_AND:   x_wval = a_q & b_q;
      r32x_pkg::OP_ANDI:  x_wval = a_q & ze;
      r32x_pkg::OP_OR:    x_wval = a_q | b_q;
      r32x_pkg::OP_ORI:   x_wval = a_q | ze;
      r32x_pkg::OP_XOR:   x_wval = a_q ^ b_q;
      r32x_pkg::OP_XORI:  x_wval = a_q ^ ze;
      r32x_pkg::OP_XNOR:  x_wval = ~(a_q ^ b_q);
      r32x_pkg::OP_XNOR_IMM: x_wval = ~(a_q ^ ze);
      r32x_pkg::OP_SLL:   x_wval = a_q << b_q[4:0];
      r32x_pkg::OP_SLLI:  x_wval = a_q << f_imm[4:0];
      r32x_pkg::OP_SLR:   x_wval = a_q >> b_q[4:0];
      r32x_pkg::OP_SLRI:  x_wval = a_q >> f_imm[4:0];
      r32x_pkg::OP_SAR:   x_wval = 32'($signed(a_q) >>> b_q[4:0]);
      r32x_pkg::OP_SARI:  x_wval = 32'($signed(a_q) >>> f_imm[4:0]);
      r32x_pkg::OP_LDHI:  x_wval = {f_imm, 16'd0};
      r32x_pkg::OP_BEQ:  begin x_wr = 1'b0; if (d == a_q) x_next = nxt + boff; end
      r32x_pkg::OP_BNE:  begin x_wr = 1'b0; if (d != a_q) x_next = nxt + boff; end
      r32x_pkg::OP_BLE:  begin
        x_wr = 1'b0;
        if ($signed(d) <= $signed(a_q)) x_next = nxt + boff;
      end
      r32x_pkg::OP_BLEU: begin x_wr = 1'b0; if (d <= a_q) x_next = nxt + boff; end
      r32x_pkg::OP_BLT:  begin
        x_wr = 1'b0;
        if ($signed(d) < $signed(a_q)) x_next = nxt + boff;
      end
      r32x_pkg::OP_BLTU: begin x_wr = 1'b0; if (d < a_q) x_next = nxt + boff; end
      r32x_pkg::OP_BGE:  begin
        x_wr = 1'b0;
        if ($signed(d) >= $signed(a_q)) x_next = nxt + boff;
      end
      r32x_pkg::OP_BGEU: begin x_wr = 1'b0; if (d >= a_q) x_next = nxt + boff; end
      r32x_pkg::OP_BGT:  begin
        x_wr = 1'b0;
        if ($signed(d) > $signed(a_q)) x_next = nxt + boff;
      end
      r32x_pkg::OP_BGTU: begin x_wr = 1'b0; if (d > a_q) x_next = nxt + boff; end
      r32x_pkg::OP_J: begin
        x_wr   = 1'b0;
        x_next = nxt + {{4{f_joff[25]}}, f_joff, 2'b00};
      end
      r32x_pkg::OP_JR: begin
        x_wr   = 1'b0;
        x_next = d;
      end
      r32x_pkg::OP_JAL: begin
        x_wreg = r32x_pkg::LINK_REG;
        x_wval = nxt;
        x_next = nxt + {{4{f_joff[25]}}, f_joff, 2'b00};
      end
      r32x_pkg::OP_JALR: begin
        x_wreg = r32x_pkg::LINK_REG;
        x_wval = nxt;
        x_next = d;
      end
      r32x_pkg::OP_TRAP: x_exc = r32x_pkg::EXC_TRP;
      r32x_pkg::OP_RFX: begin
        x_wr = 1'b0;
        x_s[r32x_pkg::S_IE]  = status[r32x_pkg::S_PIE];
        x_s[r32x_pkg::S_PIE] = status[r32x_pkg::S_OIE];
        x_s[r32x_pkg::S_UM]  = status[r32x_pkg::S_PUM];
        x_s[r32x_pkg::S_PUM] = status[r32x_pkg::S_OUM];
        x_next = rd1;
      end
      r32x_pkg::OP_MVFS: begin
        if (f_imm != 16'd0) x_exc = r32x_pkg::EXC_ILL;
        else x_wval = status;
      end
      r32x_pkg::OP_MVTS: begin
        x_wr = 1'b0;
        if (status[r32x_pkg::S_UM]) x_exc = r32x_pkg::EXC_PRV;
        else if (f_imm != 16'd0) x_exc = r32x_pkg::EXC_ILL;
        else x_s = d;
      end
      default: x_exc = r32x_pkg::EXC_ILL;
    endcase
  end

  assign div_start = (state == r32x_pkg::ST_EXEC) && (f_op[5:3] == 3'b001)
                     && (x_exc == r32x_pkg::EXC_NONE);

  r32x_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (x_dvd),
    .divisor  (x_dsr),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  always_ff @(posedge clk) begin
    if (state == r32x_pkg::ST_EXEC) begin
      ex_wval  <= x_wval;
      ex_next  <= x_next;
      ex_s     <= x_s;
      ex_exc   <= x_exc;
      ex_wreg  <= x_wreg;
      ex_wr    <= x_wr && (x_wreg != 5'd0);
      ex_isdiv <= (f_op[5:3] == 3'b001);
      ex_rem   <= f_op[2];
      ex_neg   <= x_neg;
    end
  end

  // finish: commit, then pick the highest visible pending source
  logic [31:0] fin_val, fin_pend, fin_s, fin_pc, seen, new_s;
  logic [31:0] mag;
  logic [4:0]  prio;
  logic        fin_wb, take, fin_ok;

  always_comb begin
    mag     = ex_rem ? div_r : div_q;
    fin_val = ex_isdiv ? (ex_neg ? (32'd0 - mag) : mag) : ex_wval;
    fin_ok  = (ex_exc == r32x_pkg::EXC_NONE);
    fin_pend = pending | {16'd0, f_irq};
    if (!fin_ok) fin_pend[ex_exc] = 1'b1;
    fin_s  = fin_ok ? ex_s : status;
    fin_pc = fin_ok ? ex_next : pc;
    fin_wb = fin_ok && ex_wr;
    seen   = fin_pend & {16'hFFFF, fin_s[15:0]};
    prio   = '0;
    for (int i = 0; i < 32; i++) begin
      if (seen[i]) prio = 5'(i);
    end
    take  = (seen != 32'd0) && (prio[4] || fin_s[r32x_pkg::S_IE]);
    new_s = fin_s;
    new_s[20:16] = prio;
    new_s[r32x_pkg::S_OIE] = fin_s[r32x_pkg::S_PIE];
    new_s[r32x_pkg::S_PIE] = fin_s[r32x_pkg::S_IE];
    new_s[r32x_pkg::S_IE]  = 1'b0;
    new_s[r32x_pkg::S_OUM] = fin_s[r32x_pkg::S_PUM];
    new_s[r32x_pkg::S_PUM] = fin_s[r32x_pkg::S_UM];
    new_s[r32x_pkg::S_UM]  = 1'b0;
  end

  // write port: result in the finish cycle, saved pc in the cycle after
  always_comb begin
    we = 1'b0;
    wa = ex_wreg;
    wd = fin_val;
    if (state == r32x_pkg::ST_FIN && fin_go && fin_wb) we = 1'b1;
    if (state == r32x_pkg::ST_R30) begin
      we = 1'b1;
      wa = r32x_pkg::SAVE_REG;
      wd = save_pc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= r32x_pkg::RESET_PC;
      status    <= '0;
      pending   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == r32x_pkg::ST_FIN && fin_go) begin
        out_valid <= 1'b1;
        if (take) begin
          pending <= fin_pend & ~(32'd1 << prio);
          status  <= new_s;
          pc      <= r32x_pkg::VEC_ADDR;
        end else begin
          pending <= fin_pend;
          status  <= fin_s;
          pc      <= fin_pc;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == r32x_pkg::ST_FIN && fin_go) begin
      save_pc        <= fin_pc;
      fetch_pc       <= take ? r32x_pkg::VEC_ADDR : fin_pc;
      wb_enable      <= fin_wb;
      wb_reg         <= fin_wb ? ex_wreg : 5'd0;
      wb_value       <= fin_wb ? fin_val : 32'd0;
      status_word    <= take ? new_s : fin_s;
      took_interrupt <= take;
      taken_priority <= take ? prio : 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= r32x_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      r32x_pkg::ST_IDLE:  if (in_valid) state_next = r32x_pkg::ST_RD_AB;
      r32x_pkg::ST_RD_AB: state_next = r32x_pkg::ST_RD_DL;
      r32x_pkg::ST_RD_DL: state_next = r32x_pkg::ST_EXEC;
      r32x_pkg::ST_EXEC:  state_next = div_start ? r32x_pkg::ST_DIV : r32x_pkg::ST_FIN;
      r32x_pkg::ST_DIV:   if (div_done) state_next = r32x_pkg::ST_FIN;
      r32x_pkg::ST_FIN:
        if (fin_go) state_next = take ? r32x_pkg::ST_R30 : r32x_pkg::ST_IDLE;
      r32x_pkg::ST_R30:   state_next = r32x_pkg::ST_IDLE;
      default:            state_next = r32x_pkg::ST_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == r32x_pkg::ST_R30) |-> ($past(state) == r32x_pkg::ST_FIN))
    else $error("r30 save without a finish cycle");
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == r32x_pkg::ST_RD_AB))
    else $error("transfer did not start operand read");
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == r32x_pkg::ST_FIN))
    else $error("result shown outside finish");
  assert property (@(posedge clk) disable iff (rst) we |-> (wa != 5'd0))
    else $error("write to r0");
  assert property (@(posedge clk) disable iff (rst)
    (state == r32x_pkg::ST_DIV) |-> (div_busy || div_done))
    else $error("waiting on idle divider");

endmodule
